>>> rtl/msbq_pkg.sv
package msbq_pkg;

    localparam int DEF_NODES           = 4096;
    localparam int DEF_SCORE_INT_BITS  = 16;
    localparam int DEF_SCORE_FRAC_BITS = 8;

    localparam int OPCODE_W    = 2;
    localparam int NODE_ID_W   = 12;
    localparam int INCREMENT_W = 24;
    localparam int BUCKET_W    = 16;
    localparam int STATUS_W    = 2;
    localparam int NODE_CNT_W  = 13;

    localparam logic [NODE_CNT_W-1:0] NODE_COUNT_RESET = 13'd4096;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD   = 2'd0,
        OP_TOP   = 2'd1,
        OP_ERASE = 2'd2,
        OP_CLEAR = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_REJ  = 2'd2,
        ST_SAT  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FSM_INIT,
        FSM_IDLE,
        FSM_MOD,
        FSM_SCAN,
        FSM_CLR,
        FSM_DONE
    } fsm_t;

endpackage

>>> rtl/max_score_bucket_queue_core.sv
// channel | dir | handshake            | tdata fields (low bit up)
// s_      | in  | s_tvalid / s_tready  | opcode[1:0] node_id[13:2] increment[37:14]
// m_      | out | m_tvalid / m_tready  | node_id_out[11:0] top_bucket[27:12] status[29:28]
// cfg     | in  | cfg_wr_en            | node_count[12:0]
//
// Add and erase go through read, modify/write and output steps; one rejected for a zero
// increment or an out-of-range id goes from the read step straight to output.
// Top scans the node memories one id per cycle, over up to min(node_count, NODES) ids.
// An erase of a node in the nonzero top bucket also scans all in-range ids for the new
// top bucket. Clear sweeps the score memory over all NODES entries; after reset a sweep
// clears both memories before the first request is taken.
// A result waits in the output register; the next request is taken meanwhile.
module max_score_bucket_queue_core
    import msbq_pkg::*;
#(
    parameter int NODES           = DEF_NODES,
    parameter int SCORE_INT_BITS  = DEF_SCORE_INT_BITS,
    parameter int SCORE_FRAC_BITS = DEF_SCORE_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [NODE_CNT_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // opcode[1:0], node_id[13:2], increment[37:14], zero fill
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // node_id_out[11:0], top_bucket[27:12], status[29:28], zero fill
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int SB    = SCORE_INT_BITS + SCORE_FRAC_BITS;
    localparam int SUM_W = ((SB > INCREMENT_W) ? SB : INCREMENT_W) + 1;
    localparam int AW    = $clog2(NODES);
    localparam int CW    = $clog2(NODES + 1);
    localparam int LIM_W = (CW > NODE_CNT_W) ? CW : NODE_CNT_W;
    localparam logic [SUM_W-1:0] SCORE_MAX = SUM_W'({SB{1'b1}});
    localparam logic [LIM_W-1:0] NODES_C   = LIM_W'(NODES);
    localparam logic [LIM_W-1:0] LAST_C    = LIM_W'(NODES - 1);

    logic [SB-1:0] score_mem [NODES];
    logic          taken_mem [NODES];

    fsm_t                     state_reg, state_next;
    logic [LIM_W-1:0]         cnt_reg, cnt_next;
    logic                     p_vld_reg, p_vld_next;
    logic [NODE_ID_W-1:0]     p_id_reg, p_id_next;
    opcode_t                  op_reg, op_next;
    logic [NODE_ID_W-1:0]     id_reg, id_next;
    logic [INCREMENT_W-1:0]   inc_reg, inc_next;
    logic [SCORE_INT_BITS-1:0] max_bucket_reg, max_bucket_next;
    logic [SCORE_INT_BITS-1:0] best_reg, best_next;
    logic [NODE_ID_W-1:0]     res_id_reg, res_id_next;
    status_t                  res_st_reg, res_st_next;
    logic [NODE_CNT_W-1:0]    node_count_reg;
    logic                     m_valid_reg, m_valid_next;
    logic [NODE_ID_W-1:0]     out_id_reg, out_id_next;
    logic [BUCKET_W-1:0]      out_bkt_reg, out_bkt_next;
    status_t                  out_st_reg, out_st_next;

    logic [SB-1:0]   rd_score_reg;
    logic            rd_taken_reg;
    logic [AW-1:0]   rd_addr, wr_addr;
    logic            sc_we, tk_we, tk_wd;
    logic [SB-1:0]   sc_wd;

    logic [LIM_W-1:0]          lim, nc_ext;
    opcode_t                   in_op;
    logic [NODE_ID_W-1:0]      in_id;
    logic [INCREMENT_W-1:0]    in_inc;
    logic                      in_range;
    logic [SUM_W-1:0]          sum;
    logic                      sat;
    logic [SB-1:0]             new_score;
    logic [SCORE_INT_BITS-1:0] new_bkt, rd_bkt;

    assign nc_ext = LIM_W'(node_count_reg);
    assign lim    = (nc_ext < NODES_C) ? nc_ext : NODES_C;
    assign in_op  = opcode_t'(s_tdata[1:0]);
    assign in_id  = s_tdata[13:2];
    assign in_inc = s_tdata[37:14];
    assign in_range = LIM_W'(in_id) < lim;

    assign sum       = SUM_W'(rd_score_reg) + SUM_W'(inc_reg);
    assign sat       = sum > SCORE_MAX;
    assign new_score = sat ? {SB{1'b1}} : sum[SB-1:0];
    assign new_bkt   = new_score[SB-1:SCORE_FRAC_BITS];
    assign rd_bkt    = rd_score_reg[SB-1:SCORE_FRAC_BITS];

    assign s_tready = (state_reg == FSM_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_st_reg, out_bkt_reg, out_id_reg};

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        p_vld_next      = 1'b0;
        p_id_next       = p_id_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        inc_next        = inc_reg;
        max_bucket_next = max_bucket_reg;
        best_next       = best_reg;
        res_id_next     = res_id_reg;
        res_st_next     = res_st_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_id_next     = out_id_reg;
        out_bkt_next    = out_bkt_reg;
        out_st_next     = out_st_reg;
        rd_addr         = cnt_reg[AW-1:0];
        wr_addr         = AW'(id_reg);
        sc_we           = 1'b0;
        sc_wd           = new_score;
        tk_we           = 1'b0;
        tk_wd           = 1'b1;

        unique case (state_reg)
            FSM_INIT: begin
                wr_addr  = cnt_reg[AW-1:0];
                sc_we    = 1'b1;
                sc_wd    = '0;
                tk_we    = 1'b1;
                tk_wd    = 1'b0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_C) begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE: begin
                rd_addr = AW'(in_id);
                if (s_tvalid) begin
                    op_next     = in_op;
                    id_next     = in_id;
                    inc_next    = in_inc;
                    res_id_next = in_id;
                    res_st_next = ST_OK;
                    cnt_next    = '0;
                    best_next   = '0;
                    unique case (in_op)
                        OP_ADD: begin
                            if (in_inc == '0 || !in_range) begin
                                res_st_next = ST_REJ;
                                state_next  = FSM_DONE;
                            end else begin
                                state_next = FSM_MOD;
                            end
                        end
                        OP_ERASE: begin
                            if (!in_range) begin
                                res_st_next = ST_REJ;
                                state_next  = FSM_DONE;
                            end else begin
                                state_next = FSM_MOD;
                            end
                        end
                        OP_TOP: begin
                            state_next = FSM_SCAN;
                        end
                        OP_CLEAR: begin
                            max_bucket_next = '0;
                            state_next      = FSM_CLR;
                        end
                        default: state_next = FSM_IDLE;
                    endcase
                end
            end
            FSM_MOD: begin
                state_next = FSM_DONE;
                if (op_reg == OP_ADD) begin
                    // taken nodes ignore adds
                    if (!rd_taken_reg) begin
                        sc_we = 1'b1;
                        if (sat) begin
                            res_st_next = ST_SAT;
                        end
                        if (new_bkt > max_bucket_reg) begin
                            max_bucket_next = new_bkt;
                        end
                    end
                end else if (rd_taken_reg) begin
                    res_st_next = ST_REJ;
                end else begin
                    tk_we = 1'b1;
                    if (rd_bkt == max_bucket_reg && max_bucket_reg != '0) begin
                        state_next = FSM_SCAN;
                    end
                end
            end
            FSM_SCAN: begin
                if (cnt_reg < lim) begin
                    cnt_next   = cnt_reg + 1'b1;
                    p_vld_next = 1'b1;
                    p_id_next  = NODE_ID_W'(cnt_reg);
                end
                if (p_vld_reg && !rd_taken_reg) begin
                    if (op_reg == OP_TOP) begin
                        if (max_bucket_reg == '0 || rd_bkt == max_bucket_reg) begin
                            res_id_next = p_id_reg;
                            p_vld_next  = 1'b0;
                            state_next  = FSM_DONE;
                        end
                    end else if (rd_bkt > best_reg && rd_bkt <= max_bucket_reg) begin
                        best_next = rd_bkt;
                    end
                end
                if (!p_vld_reg && cnt_reg >= lim) begin
                    state_next = FSM_DONE;
                    if (op_reg == OP_TOP) begin
                        res_id_next = '0;
                        res_st_next = ST_NONE;
                    end else begin
                        max_bucket_next = best_reg;
                    end
                end
            end
            FSM_CLR: begin
                wr_addr  = cnt_reg[AW-1:0];
                sc_we    = 1'b1;
                sc_wd    = '0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_C) begin
                    state_next = FSM_DONE;
                end
            end
            FSM_DONE: begin
                // hold until the output register frees up
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    out_id_next  = res_id_reg;
                    out_bkt_next = BUCKET_W'(max_bucket_reg);
                    out_st_next  = res_st_reg;
                    state_next   = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (sc_we) begin
            score_mem[wr_addr] <= sc_wd;
        end
        if (tk_we) begin
            taken_mem[wr_addr] <= tk_wd;
        end
        rd_score_reg <= score_mem[rd_addr];
        rd_taken_reg <= taken_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= FSM_INIT;
            cnt_reg        <= '0;
            p_vld_reg      <= 1'b0;
            max_bucket_reg <= '0;
            node_count_reg <= NODE_COUNT_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            p_vld_reg      <= p_vld_next;
            max_bucket_reg <= max_bucket_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                node_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p_id_reg    <= p_id_next;
        op_reg      <= op_next;
        id_reg      <= id_next;
        inc_reg     <= inc_next;
        best_reg    <= best_next;
        res_id_reg  <= res_id_next;
        res_st_reg  <= res_st_next;
        out_id_reg  <= out_id_next;
        out_bkt_reg <= out_bkt_next;
        out_st_reg  <= out_st_next;
    end

    a_init_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == FSM_INIT |-> !s_tready)
        else $error("request taken during memory init");

    a_clr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == FSM_CLR |-> max_bucket_reg == '0)
        else $error("top bucket nonzero during clear");

    a_none_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_st_reg == ST_NONE |-> out_id_reg == '0)
        else $error("empty top result carries a node id");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg != FSM_IDLE)
        else $error("request accepted but sequencer stayed idle");

endmodule
